>>> sv/olid_pkg.sv
// Shared types and constants for the ordered list block.
`timescale 1ns / 1ps

package olid_pkg;

    localparam int CMD_W     = 2;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Command codes; code 3 behaves as a remove.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic upd;   // apply the accepted command to the store
        logic load;  // load the next element into the output register
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last_one;  // the element being read is the final one of the run
    } dp_stat_t;

endpackage

>>> sv/olid_ctrl.sv
// Controller: command acceptance and readout sequencing.
`timescale 1ns / 1ps

module olid_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  olid_pkg::dp_stat_t   stat,
    output olid_pkg::ctrl_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.upd    = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.upd    = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    if (stat.last_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> sv/olid_dpath.sv
// Datapath: shifting element store, length counter and output register.
`timescale 1ns / 1ps

module olid_dpath #(
    parameter int CAPACITY = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  olid_pkg::ctrl_cmd_t            cmd,
    output olid_pkg::dp_stat_t             stat,
    input  logic [olid_pkg::CMD_W-1:0]     in_cmd,
    input  logic [olid_pkg::VAL_W-1:0]     in_value,
    input  logic [olid_pkg::POS_W-1:0]     in_pos,
    output logic [olid_pkg::VAL_W-1:0]     out_element,
    output logic                           out_last,
    output logic                           out_empty,
    output logic                           out_dropped
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [olid_pkg::VAL_W-1:0] cells_reg  [CAPACITY];
    logic [olid_pkg::VAL_W-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           idx_reg;
    logic                       drop_reg;
    logic [olid_pkg::VAL_W-1:0] elem_reg;
    logic                       last_reg;
    logic                       empty_reg;
    logic                       dropped_reg;
    logic                       full;
    logic                       is_push;
    logic                       pos_ok;
    logic                       list_empty;

    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign is_push    = (in_cmd == olid_pkg::CMD_PUSH_FRONT) ||
                        (in_cmd == olid_pkg::CMD_PUSH_BACK);
    assign pos_ok     = (32'(in_pos) < 32'(count_reg));
    assign list_empty = (count_reg == '0);

    // Each cell picks from itself, its front or back neighbor, or the new value.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [olid_pkg::VAL_W-1:0] prev_w;
        logic [olid_pkg::VAL_W-1:0] next_w;

        if (g == 0) begin : g_head
            assign prev_w = in_value;
        end else begin : g_body
            assign prev_w = cells_reg[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_w = cells_reg[g];
        end else begin : g_nxt
            assign next_w = cells_reg[g+1];
        end

        always_comb begin
            cells_next[g] = cells_reg[g];
            case (in_cmd)
                olid_pkg::CMD_PUSH_FRONT: begin
                    if (!full) begin
                        cells_next[g] = prev_w;
                    end
                end
                olid_pkg::CMD_PUSH_BACK: begin
                    if (!full && (32'(g) == 32'(count_reg))) begin
                        cells_next[g] = in_value;
                    end
                end
                default: begin
                    if (pos_ok && (32'(g) >= 32'(in_pos))) begin
                        cells_next[g] = next_w;
                    end
                end
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        if (is_push) begin
            if (!full) begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (pos_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign stat.last_one = list_empty || ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            cells_reg <= cells_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else if (cmd.upd) begin
            count_reg <= count_next;
            idx_reg   <= '0;
        end else if (cmd.load) begin
            idx_reg <= stat.last_one ? '0 : idx_reg + IDX_W'(1);
        end
    end

    // The drop flag travels with each element so a waiting result keeps its own.
    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            drop_reg <= is_push && full;
        end
        if (cmd.load) begin
            elem_reg    <= list_empty ? '0 : cells_reg[idx_reg];
            last_reg    <= stat.last_one;
            empty_reg   <= list_empty;
            dropped_reg <= drop_reg;
        end
    end

    assign out_element = elem_reg;
    assign out_last    = last_reg;
    assign out_empty   = empty_reg;
    assign out_dropped = dropped_reg;

endmodule

>>> sv/ordered_list_with_indexed_delete.sv
// Top level of the ordered list with insert at front, append and indexed remove.
`timescale 1ns / 1ps

// Keeps an ordered list of up to CAPACITY signed 32-bit values. Each input
// transfer carries one command: insert at the front, append at the back, or
// remove the element at a position (code 3 also removes). A remove at or past
// the current length is ignored; an insert into a full list is dropped and
// every result of that command has insert_dropped set. After each command the
// whole list is sent front to back, one element per output transfer, with
// tlast on the final one; an empty list gives one transfer with list_empty set
// and element zero. The store updates in the cycle the command is accepted,
// then the readout sends one element per cycle while the output is not
// stalled, so a command holds the block until the last element of its list
// is loaded for output. The output register lets the next command be
// accepted while the final result still waits to be taken.
module ordered_list_with_indexed_delete #(
    parameter int CAPACITY = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Command channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] cmd, [33:2] item_value, [38:34] position, [39] zero
    input  logic [olid_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] element
    output logic [olid_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    // [0] list_empty, [1] insert_dropped
    output logic [olid_pkg::M_TUSER_W-1:0]   m_tuser
);

    olid_pkg::ctrl_cmd_t ctrl_cmd;
    olid_pkg::dp_stat_t  dp_stat;

    logic [olid_pkg::CMD_W-1:0] in_cmd;
    logic [olid_pkg::VAL_W-1:0] in_value;
    logic [olid_pkg::POS_W-1:0] in_pos;
    logic                       out_empty;
    logic                       out_dropped;

    // Unpack the command transfer.
    assign in_cmd   = s_tdata[1:0];
    assign in_value = s_tdata[33:2];
    assign in_pos   = s_tdata[38:34];

    olid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    olid_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (ctrl_cmd),
        .stat        (dp_stat),
        .in_cmd      (in_cmd),
        .in_value    (in_value),
        .in_pos      (in_pos),
        .out_element (m_tdata),
        .out_last    (m_tlast),
        .out_empty   (out_empty),
        .out_dropped (out_dropped)
    );

    assign m_tuser = {out_dropped, out_empty};

endmodule

>>> test/olid_readout_checker.sv
// Checker for the ordered list: predicts each readout from the commands and compares.
`timescale 1ns / 1ps

module olid_readout_checker
    import olid_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   mismatches,
    output int                   pending
);

    typedef struct packed {
        logic [VAL_W-1:0] element;
        logic             last_of_run;
        logic             list_empty;
        logic             insert_dropped;
    } readout_t;

    logic [VAL_W-1:0] store [CAPACITY];
    int               depth;
    readout_t         readout_q [$];

    initial begin
        mismatches = 0;
        pending    = 0;
        depth      = 0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] list readout mismatch: %s", $time, what);
    endtask

    // Apply one command to the local copy of the list and queue its readout.
    task automatic predict_readout(input logic [CMD_W-1:0] op,
                                   input logic [VAL_W-1:0] value,
                                   input logic [POS_W-1:0] pos);
        logic     refused;
        readout_t r;
        int       i;
        refused = 1'b0;
        case (op)
            CMD_PUSH_FRONT: begin
                if (depth >= CAPACITY) begin
                    refused = 1'b1;
                end else begin
                    for (i = depth; i > 0; i--)
                        store[i] = store[i-1];
                    store[0] = value;
                    depth++;
                end
            end
            CMD_PUSH_BACK: begin
                if (depth >= CAPACITY) begin
                    refused = 1'b1;
                end else begin
                    store[depth] = value;
                    depth++;
                end
            end
            default: begin
                // remove, also for the spare code
                if (int'(pos) < depth) begin
                    for (i = int'(pos); i + 1 < depth; i++)
                        store[i] = store[i+1];
                    depth--;
                end
            end
        endcase
        if (depth == 0) begin
            r = '{element: '0, last_of_run: 1'b1, list_empty: 1'b1,
                  insert_dropped: refused};
            readout_q.push_back(r);
        end else begin
            for (i = 0; i < depth; i++) begin
                r = '{element: store[i], last_of_run: (i == depth - 1),
                      list_empty: 1'b0, insert_dropped: refused};
                readout_q.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin
        readout_t want;
        if (!aresetn) begin
            depth = 0;
            readout_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_readout(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: VAL_W],
                                s_tdata[CMD_W+VAL_W +: POS_W]);
            if (m_tvalid && m_tready) begin
                if (readout_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transfer, element %h",
                                            m_tdata));
                end else begin
                    want = readout_q.pop_front();
                    if (m_tdata !== want.element)
                        flag_mismatch($sformatf("element %h, want %h",
                                                m_tdata, want.element));
                    if (m_tlast !== want.last_of_run)
                        flag_mismatch($sformatf("tlast %b, want %b",
                                                m_tlast, want.last_of_run));
                    if (m_tuser[0] !== want.list_empty)
                        flag_mismatch($sformatf("list_empty %b, want %b",
                                                m_tuser[0], want.list_empty));
                    if (m_tuser[1] !== want.insert_dropped)
                        flag_mismatch($sformatf("insert_dropped %b, want %b",
                                                m_tuser[1], want.insert_dropped));
                end
            end
        end
        pending = readout_q.size();
    end

endmodule

>>> test/ordered_list_with_indexed_delete_tb.sv
// Testbench top for the ordered list: drives commands, paces the result channel, gives the verdict.
`timescale 1ns / 1ps

module ordered_list_with_indexed_delete_tb;
    import olid_pkg::*;

    localparam int LIST_CAP = 32;
    // Spare command code; the block treats it as a remove.
    localparam logic [CMD_W-1:0] CMD_REMOVE_ALT = 2'd3;
    localparam int RANDOM_PER_PHASE = 113;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] cmd, [33:2] item_value, [38:34] position, [39] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [31:0] element
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    // [0] list_empty, [1] insert_dropped
    logic [M_TUSER_W-1:0] m_tuser;

    int mismatches;
    int pending;

    // Stimulus pacing, percent of cycles spent idle / stalled.
    int idle_pct  = 0;
    int stall_pct = 0;
    // Rough length of the list as the sender sees it; only steers stimulus.
    int fill_est  = 0;
    bit growing   = 1'b1;

    ordered_list_with_indexed_delete #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    olid_readout_checker #(
        .CAPACITY (LIST_CAP)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: back-pressure redrawn every falling edge.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= stall_pct);
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20_000_000;
        $display("ordered_list_with_indexed_delete regression: fail");
        $finish;
    end

    // One command transfer. Entered and left at a falling edge; tvalid is left
    // high so back-to-back transfers need no gap.
    task automatic send_cmd(input logic [CMD_W-1:0] op,
                            input logic [VAL_W-1:0] value,
                            input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, pos, value, op};
        do
            @(posedge aclk);
        while (!s_tready);
        // track the length as the block should see it
        if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
            if (fill_est < LIST_CAP)
                fill_est++;
        end else if (int'(pos) < fill_est) begin
            fill_est--;
        end
        @(negedge aclk);
    endtask

    // Mostly random words, with the sign and all-ones/zero corners mixed in.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random walk that fills the list to capacity (where inserts get dropped)
    // and drains it back to empty, so every length is visited repeatedly.
    task automatic random_cmd();
        logic [CMD_W-1:0] op;
        logic [POS_W-1:0] pos;
        bit               do_insert;
        if (growing && fill_est >= LIST_CAP && $urandom_range(3) == 0)
            growing = 1'b0;
        else if (!growing && fill_est == 0 && $urandom_range(2) == 0)
            growing = 1'b1;
        do_insert = growing ? ($urandom_range(99) < 85) : ($urandom_range(99) < 15);
        if (do_insert)
            op = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else
            op = ($urandom_range(3) == 0) ? CMD_REMOVE_ALT : CMD_REMOVE;
        // removes mostly hit a live entry; the rest land anywhere, often past the end
        if (fill_est > 0 && $urandom_range(9) < 8)
            pos = POS_W'($urandom_range(fill_est - 1));
        else
            pos = POS_W'($urandom_range(31));
        send_cmd(op, pick_value(), pos);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: removes on an empty list, value extremes at both ends,
        // removes past the end, at the tail, front and middle, spare code.
        send_cmd(CMD_REMOVE,     32'h1234_5678, 5'd0);
        send_cmd(CMD_REMOVE_ALT, 32'hFFFF_FFFF, 5'd31);
        send_cmd(CMD_PUSH_BACK,  32'h7FFF_FFFF, 5'd31);
        send_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 5'd0);
        send_cmd(CMD_PUSH_BACK,  32'h0000_0000, 5'd21);
        send_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 5'd10);
        send_cmd(CMD_PUSH_BACK,  32'h0000_0001, 5'd0);
        send_cmd(CMD_REMOVE,     32'h0,         5'd31);  // far past the end
        send_cmd(CMD_REMOVE,     32'h0,         5'd5);   // exactly at length
        send_cmd(CMD_REMOVE,     32'h0,         5'd4);   // tail
        send_cmd(CMD_REMOVE_ALT, 32'h0,         5'd0);   // head
        send_cmd(CMD_REMOVE,     32'h0,         5'd1);   // middle
        send_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA, 5'd15);
        send_cmd(CMD_PUSH_BACK,  32'h5555_5555, 5'd16);
        repeat (4) send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 5'd0);
        send_cmd(CMD_REMOVE,     32'h0,         5'd0);   // empty again

        // Random part in four pacing phases: none, sender gaps,
        // receiver stalls, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            repeat (RANDOM_PER_PHASE) random_cmd();
        end
        s_tvalid = 1'b0;

        // Drain, then leave room for anything stray to show up.
        while (pending != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("ordered_list_with_indexed_delete regression: pass");
        end else begin
            $display("ordered_list_with_indexed_delete regression: fail");
        end
        $finish;
    end

endmodule
